// ----- rtl/tcd_pkg.sv -----
package tcd_pkg;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_SCAN  = 2'd1,
        PH_LOOK  = 2'd2,
        PH_VALID = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ENC_ENGLISH = 3'd0,
        ENC_UTF8    = 3'd1,
        ENC_GB2312  = 3'd2,
        ENC_GBK     = 3'd3,
        ENC_BIG5    = 3'd4,
        ENC_ERROR   = 3'd5
    } t_enc;

    typedef enum logic [1:0] {
        SCH_GB2312 = 2'd0,
        SCH_GBK    = 2'd1,
        SCH_BIG5   = 2'd2
    } t_scheme;

    localparam int unsigned NUM_SCHEMES = 3;

    localparam logic [7:0] GB_LEAD_LO  = 8'hB0;
    localparam logic [7:0] GB_LEAD_HI  = 8'hF7;
    localparam logic [7:0] GB_TRAIL_LO = 8'hA0;
    localparam logic [7:0] DB_HI       = 8'hFE;
    localparam logic [7:0] DB_LEAD_LO  = 8'h81;
    localparam logic [7:0] DB_TRAIL_LO = 8'h40;
    localparam logic [7:0] B5_TRAIL_HI = 8'h7E;
    localparam logic [7:0] B5_TRAIL_LO = 8'hA1;
    localparam logic [7:0] U8_LEAD2    = 8'hC0;
    localparam logic [7:0] U8_LEAD3    = 8'hE0;
    localparam logic [7:0] U8_BAD      = 8'hF0;
    localparam logic [7:0] ASCII_END   = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic valid;
        t_enc code;
    } t_result;

    function automatic logic lead_ok(t_scheme s, logic [7:0] c);
        if (s == SCH_GB2312) begin
            return (c >= GB_LEAD_LO) && (c <= GB_LEAD_HI);
        end
        return (c >= DB_LEAD_LO) && (c <= DB_HI);
    endfunction

    function automatic logic trail_ok(t_scheme s, logic [7:0] c);
        if (s == SCH_GB2312) begin
            return (c >= GB_TRAIL_LO) && (c <= DB_HI);
        end
        if (s == SCH_GBK) begin
            return (c >= DB_TRAIL_LO) && (c <= DB_HI);
        end
        return ((c >= DB_TRAIL_LO) && (c <= B5_TRAIL_HI)) ||
               ((c >= B5_TRAIL_LO) && (c <= DB_HI));
    endfunction

    function automatic logic is_cont(logic [7:0] c);
        return c[7:6] == 2'b10;
    endfunction

    function automatic t_enc scheme_code(t_scheme s);
        t_enc e;
        unique case (s)
            SCH_GB2312: e = ENC_GB2312;
            SCH_GBK:    e = ENC_GBK;
            SCH_BIG5:   e = ENC_BIG5;
            default:    e = ENC_ERROR;
        endcase
        return e;
    endfunction

    function automatic t_enc first_char_code(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3);
        if (c1 < ASCII_END) begin
            return ENC_UTF8;
        end
        if ((c1 >= U8_LEAD2) && (c1 < U8_LEAD3) && is_cont(c2)) begin
            return ENC_UTF8;
        end
        if ((c1 >= U8_LEAD3) && (c1 < U8_BAD) && is_cont(c2) && is_cont(c3)) begin
            return ENC_UTF8;
        end
        if (lead_ok(SCH_GB2312, c1) && trail_ok(SCH_GB2312, c2)) begin
            return ENC_GB2312;
        end
        if (lead_ok(SCH_GBK, c1) && trail_ok(SCH_GBK, c2)) begin
            return ENC_GBK;
        end
        if (lead_ok(SCH_BIG5, c1) && trail_ok(SCH_BIG5, c2)) begin
            return ENC_BIG5;
        end
        return ENC_ERROR;
    endfunction

endpackage

// ----- rtl/tcd_core.sv -----
module tcd_core
    import tcd_pkg::*;
#(
    parameter int START_OFFSETS = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int DBCS_OFFSETS = (START_OFFSETS < 2) ? START_OFFSETS : 2;
    localparam int DBCS_COUNT   = NUM_SCHEMES * DBCS_OFFSETS;

    t_phase     r_phase, n_phase;
    logic [1:0] r_pos, n_pos;
    logic [7:0] r_look [2];
    logic [7:0] n_look [2];
    logic [1:0] r_count, n_count;
    t_enc       r_decided, n_decided;
    logic [1:0] r_u_exp   [START_OFFSETS];
    logic [1:0] n_u_exp   [START_OFFSETS];
    logic       r_u_alive [START_OFFSETS];
    logic       n_u_alive [START_OFFSETS];
    logic       r_d_pend  [DBCS_COUNT];
    logic       n_d_pend  [DBCS_COUNT];
    logic       r_d_alive [DBCS_COUNT];
    logic       n_d_alive [DBCS_COUNT];

    logic       feed_en;
    logic [7:0] b;
    logic [7:0] f2, f3;
    t_enc       fc_code;
    t_enc       verdict;
    logic       found;
    logic       started;
    t_enc       code;

    assign b = i_item.data;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_look    = r_look;
        n_count   = r_count;
        n_decided = r_decided;
        n_u_exp   = r_u_exp;
        n_u_alive = r_u_alive;
        n_d_pend  = r_d_pend;
        n_d_alive = r_d_alive;
        feed_en   = 1'b0;

        unique case (r_phase)
            PH_FIRST: begin
                if (b < ASCII_END) begin
                    n_phase = PH_SCAN;
                end else begin
                    n_phase = PH_VALID;
                    feed_en = 1'b1;
                end
            end
            PH_SCAN: begin
                if (b == 8'd0) begin
                    n_decided = ENC_ENGLISH;
                    n_count   = 2'd3;
                    n_phase   = PH_LOOK;
                end else if (b >= ASCII_END) begin
                    n_look[0] = b;
                    n_count   = 2'd1;
                    n_phase   = PH_LOOK;
                end
            end
            PH_LOOK: begin
                if (r_count == 2'd1) begin
                    n_look[1] = b;
                    n_count   = 2'd2;
                end else if (r_count == 2'd2) begin
                    n_count = 2'd3;
                end
            end
            PH_VALID: begin
                feed_en = 1'b1;
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase

        f2      = (n_count >= 2'd2) ? n_look[1] : 8'd0;
        f3      = (n_count == 2'd3) ? b : 8'd0;
        fc_code = first_char_code(n_look[0], f2, f3);
        if ((r_phase == PH_LOOK) && (r_count == 2'd2)) begin
            n_decided = fc_code;
        end

        for (int i = 0; i < START_OFFSETS; i++) begin
            if (feed_en && (2'(i) <= r_pos) && r_u_alive[i]) begin
                if (r_u_exp[i] != 2'd0) begin
                    if (is_cont(b)) begin
                        n_u_exp[i] = r_u_exp[i] - 2'd1;
                    end else begin
                        n_u_alive[i] = 1'b0;
                    end
                end else if (b < ASCII_END) begin
                    n_u_exp[i] = 2'd0;
                end else if (b < U8_LEAD2) begin
                    n_u_alive[i] = 1'b0;
                end else if (b < U8_LEAD3) begin
                    n_u_exp[i] = 2'd1;
                end else if (b < U8_BAD) begin
                    n_u_exp[i] = 2'd2;
                end else begin
                    n_u_alive[i] = 1'b0;
                end
            end
        end

        for (int s = 0; s < NUM_SCHEMES; s++) begin
            for (int i = 0; i < DBCS_OFFSETS; i++) begin
                if (feed_en && (2'(i) <= r_pos) && r_d_alive[s*DBCS_OFFSETS+i]) begin
                    if (r_d_pend[s*DBCS_OFFSETS+i]) begin
                        if (trail_ok(t_scheme'(2'(s)), b)) begin
                            n_d_pend[s*DBCS_OFFSETS+i] = 1'b0;
                        end else begin
                            n_d_alive[s*DBCS_OFFSETS+i] = 1'b0;
                        end
                    end else begin
                        if (lead_ok(t_scheme'(2'(s)), b)) begin
                            n_d_pend[s*DBCS_OFFSETS+i] = 1'b1;
                        end else begin
                            n_d_alive[s*DBCS_OFFSETS+i] = 1'b0;
                        end
                    end
                end
            end
        end

        if (feed_en && (r_pos != 2'd3)) begin
            n_pos = r_pos + 2'd1;
        end

        found   = 1'b0;
        verdict = ENC_ERROR;
        started = 1'b0;
        for (int i = 0; i < START_OFFSETS; i++) begin
            started = 2'(i) < n_pos;
            if (!found) begin
                if (!started || (n_u_alive[i] && (n_u_exp[i] == 2'd0))) begin
                    found   = 1'b1;
                    verdict = ENC_UTF8;
                end
            end
            if (i < DBCS_OFFSETS) begin
                for (int s = 0; s < NUM_SCHEMES; s++) begin
                    if (!found && started && n_d_alive[s*DBCS_OFFSETS+i] &&
                        !n_d_pend[s*DBCS_OFFSETS+i]) begin
                        found   = 1'b1;
                        verdict = scheme_code(t_scheme'(2'(s)));
                    end
                end
            end
        end

        unique case (n_phase)
            PH_LOOK:  code = (n_count == 2'd3) ? n_decided : fc_code;
            PH_VALID: code = verdict;
            default:  code = ENC_ENGLISH;
        endcase

        o_result.valid = i_fire && i_item.last;
        o_result.code  = code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last)) begin
            r_phase   <= PH_FIRST;
            r_pos     <= 2'd0;
            r_count   <= 2'd0;
            r_decided <= ENC_ENGLISH;
            for (int i = 0; i < START_OFFSETS; i++) begin
                r_u_exp[i]   <= 2'd0;
                r_u_alive[i] <= 1'b1;
            end
            for (int x = 0; x < DBCS_COUNT; x++) begin
                r_d_pend[x]  <= 1'b0;
                r_d_alive[x] <= 1'b1;
            end
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_decided <= n_decided;
            r_u_exp   <= n_u_exp;
            r_u_alive <= n_u_alive;
            r_d_pend  <= n_d_pend;
            r_d_alive <= n_d_alive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_look <= n_look;
        end
    end

endmodule

// ----- rtl/text_charset_detector_unit.sv -----
// Channel   Dir  Transaction   Payload
// s_axis    in   one byte      tdata[7:0] data_byte, tlast last_byte
// m_axis    out  one code      tdata[2:0] encoding, tdata[7:3] zero
//
// One byte per cycle unless m_axis stalls a last byte; validators step per byte.
// The code passes the input register, then the output register, to m_axis.
// Reset (synchronous, active low) empties both registers and restarts detection.
// A stalled m_axis holds its code; a last byte then waits in the input register.
module text_charset_detector_unit
    import tcd_pkg::*;
#(
    parameter int START_OFFSETS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [2:0] encoding, [7:3] zero
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_enc    r_out_code;
    logic    fire;
    t_result result;

    assign fire = r_in_valid && (!r_in_item.last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    tcd_core #(
        .START_OFFSETS(START_OFFSETS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (result.valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_item.data <= s_axis_tdata;
            r_in_item.last <= s_axis_tlast;
        end
        if (result.valid) begin
            r_out_code <= result.code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_code};

endmodule

// ----- rtl/tcd_checker.sv -----
module tcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= 8'd5))
        else $error("encoding out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result present after reset");

    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_ready_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

endmodule

bind text_charset_detector_unit tcd_checker u_tcd_checker (.*);
